[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sm83_alu_pkg.sv]
// Package with the item types and opcode constants of the SM83 block 0 ALU.
package sm83_alu_pkg;

   localparam logic [7:0] OP_RLCA = 8'h07;
   localparam logic [7:0] OP_RRCA = 8'h0F;
   localparam logic [7:0] OP_RLA  = 8'h17;
   localparam logic [7:0] OP_RRA  = 8'h1F;
   localparam logic [7:0] OP_DAA  = 8'h27;
   localparam logic [7:0] OP_CPL  = 8'h2F;
   localparam logic [7:0] OP_SCF  = 8'h37;
   localparam logic [7:0] OP_CCF  = 8'h3F;

   localparam logic [3:0] LO_INC16  = 4'h3;
   localparam logic [3:0] LO_DEC16  = 4'hB;
   localparam logic [3:0] LO_ADDHL  = 4'h9;
   localparam logic [2:0] LO3_INC8  = 3'h4;
   localparam logic [2:0] LO3_DEC8  = 3'h5;
   localparam logic [1:0] BLOCK0    = 2'b00;

   localparam logic [7:0] DAA_LO_CORR = 8'h06;
   localparam logic [7:0] DAA_HI_CORR = 8'h60;
   localparam logic [7:0] DAA_HI_MAX  = 8'h99;
   localparam logic [3:0] DAA_LO_MAX  = 4'h9;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [7:0]  acc;
      logic        z_in;
      logic        n_in;
      logic        h_in;
      logic        c_in;
      logic [7:0]  reg8_in;
      logic [15:0] reg16_in;
      logic [15:0] hl_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic        z_out;
      logic        n_out;
      logic        h_out;
      logic        c_out;
      logic [7:0]  reg8_out;
      logic [15:0] reg16_out;
      logic [15:0] hl_out;
      logic        handled;
   } rsp_type;

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);

endpackage

[rtl/core/sm83_alu_stage.sv]
// Pipeline register stage with valid and stall handshake on both sides.
module sm83_alu_stage #(
   parameter int WIDTH = sm83_alu_pkg::REQ_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_stall,
   input  logic [WIDTH-1:0] up_data,
   output logic             dn_valid,
   input  logic             dn_stall,
   output logic [WIDTH-1:0] dn_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;
   logic             load;

   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = load | (valid_ff & dn_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= up_data;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[rtl/core/sm83_alu_core.sv]
// Combinational execute logic for the block 0 register arithmetic opcodes.
module sm83_alu_core (
   input  sm83_alu_pkg::req_type req,
   output sm83_alu_pkg::rsp_type rsp
);

   logic [7:0]  op;
   logic [7:0]  a;
   logic [7:0]  daa_corr;
   logic        daa_carry;
   logic [7:0]  daa_res;
   logic [7:0]  r8_inc;
   logic [7:0]  r8_dec;
   logic [16:0] hl_sum;
   logic [12:0] hl_half;

   assign op = req.opcode;
   assign a  = req.acc;

   always_comb begin
      daa_corr  = 8'h00;
      daa_carry = 1'b0;
      if (req.h_in || (!req.n_in && (a[3:0] > sm83_alu_pkg::DAA_LO_MAX))) begin
         daa_corr = daa_corr | sm83_alu_pkg::DAA_LO_CORR;
      end
      if (req.c_in || (!req.n_in && (a > sm83_alu_pkg::DAA_HI_MAX))) begin
         daa_corr  = daa_corr | sm83_alu_pkg::DAA_HI_CORR;
         daa_carry = 1'b1;
      end
   end

   assign daa_res = req.n_in ? (a - daa_corr) : (a + daa_corr);
   assign r8_inc  = req.reg8_in + 8'd1;
   assign r8_dec  = req.reg8_in - 8'd1;
   assign hl_sum  = {1'b0, req.hl_in} + {1'b0, req.reg16_in};
   assign hl_half = {1'b0, req.hl_in[11:0]} + {1'b0, req.reg16_in[11:0]};

   always_comb begin
      rsp.acc_out   = a;
      rsp.z_out     = req.z_in;
      rsp.n_out     = req.n_in;
      rsp.h_out     = req.h_in;
      rsp.c_out     = req.c_in;
      rsp.reg8_out  = req.reg8_in;
      rsp.reg16_out = req.reg16_in;
      rsp.hl_out    = req.hl_in;
      rsp.handled   = 1'b1;

      if (op[7:6] != sm83_alu_pkg::BLOCK0) begin
         rsp.handled = 1'b0;
      end else if (op == sm83_alu_pkg::OP_RLCA) begin
         rsp.acc_out = {a[6:0], a[7]};
         rsp.c_out   = a[7];
         rsp.z_out   = 1'b0;
         rsp.n_out   = 1'b0;
         rsp.h_out   = 1'b0;
      end else if (op == sm83_alu_pkg::OP_RRCA) begin
         rsp.acc_out = {a[0], a[7:1]};
         rsp.c_out   = a[0];
         rsp.z_out   = 1'b0;
         rsp.n_out   = 1'b0;
         rsp.h_out   = 1'b0;
      end else if (op == sm83_alu_pkg::OP_RLA) begin
         rsp.acc_out = {a[6:0], req.c_in};
         rsp.c_out   = a[7];
         rsp.z_out   = 1'b0;
         rsp.n_out   = 1'b0;
         rsp.h_out   = 1'b0;
      end else if (op == sm83_alu_pkg::OP_RRA) begin
         rsp.acc_out = {req.c_in, a[7:1]};
         rsp.c_out   = a[0];
         rsp.z_out   = 1'b0;
         rsp.n_out   = 1'b0;
         rsp.h_out   = 1'b0;
      end else if (op == sm83_alu_pkg::OP_DAA) begin
         rsp.acc_out = daa_res;
         rsp.z_out   = (daa_res == 8'h00);
         rsp.h_out   = 1'b0;
         rsp.c_out   = daa_carry;
      end else if (op == sm83_alu_pkg::OP_CPL) begin
         rsp.acc_out = ~a;
         rsp.n_out   = 1'b1;
         rsp.h_out   = 1'b1;
      end else if (op == sm83_alu_pkg::OP_SCF) begin
         rsp.c_out = 1'b1;
         rsp.n_out = 1'b0;
         rsp.h_out = 1'b0;
      end else if (op == sm83_alu_pkg::OP_CCF) begin
         rsp.c_out = ~req.c_in;
         rsp.n_out = 1'b0;
         rsp.h_out = 1'b0;
      end else if (op[3:0] == sm83_alu_pkg::LO_INC16) begin
         rsp.reg16_out = req.reg16_in + 16'd1;
      end else if (op[3:0] == sm83_alu_pkg::LO_DEC16) begin
         rsp.reg16_out = req.reg16_in - 16'd1;
      end else if (op[3:0] == sm83_alu_pkg::LO_ADDHL) begin
         rsp.hl_out = hl_sum[15:0];
         rsp.h_out  = hl_half[12];
         rsp.c_out  = hl_sum[16];
         rsp.n_out  = 1'b0;
      end else if (op[2:0] == sm83_alu_pkg::LO3_INC8) begin
         rsp.reg8_out = r8_inc;
         rsp.h_out    = (req.reg8_in[3:0] == 4'hF);
         rsp.z_out    = (r8_inc == 8'h00);
         rsp.n_out    = 1'b0;
      end else if (op[2:0] == sm83_alu_pkg::LO3_DEC8) begin
         rsp.reg8_out = r8_dec;
         rsp.h_out    = (req.reg8_in[3:0] == 4'h0);
         rsp.z_out    = (r8_dec == 8'h00);
         rsp.n_out    = 1'b1;
      end else begin
         rsp.handled = 1'b0;
      end
   end

endmodule

[rtl/core/sm83_block0_alu_flags.sv]
// Top level of the SM83 block 0 ALU: input register, execute logic, result register.
// The block executes the block 0 register arithmetic opcodes (rotates of A, DAA, CPL,
// SCF, CCF, INC and DEC of r8 and r16, ADD HL,r16) and returns the new register values
// and flags; other opcodes come back unchanged with rsp_handled low. An item is taken
// every cycle while req_stall is low. It is held in the input register, and its result
// is written into the result register, which drives the result ports. All arithmetic
// sits in the single logic level between the two registers. The result register holds
// its item while rsp_stall is high, and the input register holds its item while the
// result register is stalled, so the block accepts items until both stages are full.
module sm83_block0_alu_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_acc,
   input  logic        req_z_in,
   input  logic        req_n_in,
   input  logic        req_h_in,
   input  logic        req_c_in,
   input  logic [7:0]  req_reg8_in,
   input  logic [15:0] req_reg16_in,
   input  logic [15:0] req_hl_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_acc_out,
   output logic        rsp_z_out,
   output logic        rsp_n_out,
   output logic        rsp_h_out,
   output logic        rsp_c_out,
   output logic [7:0]  rsp_reg8_out,
   output logic [15:0] rsp_reg16_out,
   output logic [15:0] rsp_hl_out,
   output logic        rsp_handled
);

   sm83_alu_pkg::req_type req_in;
   sm83_alu_pkg::req_type req_q;
   sm83_alu_pkg::rsp_type rsp_in;
   sm83_alu_pkg::rsp_type rsp_q;
   logic                  mid_valid;
   logic                  mid_stall;

   always_comb begin
      req_in.opcode   = req_opcode;
      req_in.acc      = req_acc;
      req_in.z_in     = req_z_in;
      req_in.n_in     = req_n_in;
      req_in.h_in     = req_h_in;
      req_in.c_in     = req_c_in;
      req_in.reg8_in  = req_reg8_in;
      req_in.reg16_in = req_reg16_in;
      req_in.hl_in    = req_hl_in;
   end

   sm83_alu_stage #(
      .WIDTH (sm83_alu_pkg::REQ_W)
   ) u_req_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_data  (req_in),
      .dn_valid (mid_valid),
      .dn_stall (mid_stall),
      .dn_data  (req_q)
   );

   sm83_alu_core u_core (
      .req (req_q),
      .rsp (rsp_in)
   );

   sm83_alu_stage #(
      .WIDTH (sm83_alu_pkg::RSP_W)
   ) u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mid_valid),
      .up_stall (mid_stall),
      .up_data  (rsp_in),
      .dn_valid (rsp_valid),
      .dn_stall (rsp_stall),
      .dn_data  (rsp_q)
   );

   assign rsp_acc_out   = rsp_q.acc_out;
   assign rsp_z_out     = rsp_q.z_out;
   assign rsp_n_out     = rsp_q.n_out;
   assign rsp_h_out     = rsp_q.h_out;
   assign rsp_c_out     = rsp_q.c_out;
   assign rsp_reg8_out  = rsp_q.reg8_out;
   assign rsp_reg16_out = rsp_q.reg16_out;
   assign rsp_hl_out    = rsp_q.hl_out;
   assign rsp_handled   = rsp_q.handled;

endmodule

[rtl/core/sm83_alu_chk.sv]
// Port-level assertion checker for the SM83 block 0 ALU and its bind statement.
`include "assert_macros.svh"

module sm83_alu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_acc_out,
   input logic [15:0] rsp_reg16_out,
   input logic [15:0] rsp_hl_out,
   input logic        rsp_handled
);

   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "Result valid right after reset.")

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_acc_out) && $stable(rsp_reg16_out) && $stable(rsp_hl_out) && $stable(rsp_handled), "Stalled result item changed.")

   `ASSERT_CLK(a_stall_full, clock, reset, req_stall |-> rsp_valid && rsp_stall, "Input stalled while the result side is not stalled.")

   `ASSERT_CLK(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid, "Accepted item did not reach the result port in two cycles.")

endmodule

bind sm83_block0_alu_flags sm83_alu_chk u_sm83_alu_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_acc_out   (rsp_acc_out),
   .rsp_reg16_out (rsp_reg16_out),
   .rsp_hl_out    (rsp_hl_out),
   .rsp_handled   (rsp_handled)
);
